>>> src/fmte_pkg.sv
package fmte_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_MODE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_FACTOR    = CFG_IDX_W'(3);

  localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = DIM_W'(64);
  localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = DIM_W'(64);
  localparam logic [DIM_W-1:0] RESET_TILE_FACTOR  = DIM_W'(1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TILE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef enum logic [1:0] {
    MODE_MIRROR_H = 2'd0,
    MODE_MIRROR_V = 2'd1,
    MODE_TILE     = 2'd2,
    MODE_DIRECT   = 2'd3
  } mode_e;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel_in;
  } fmte_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic [1:0]         status;
  } fmte_out_t;

  typedef struct packed {
    logic load_item;
    logic load_status;
    logic mem_write;
    logic mem_read;
    logic cap_mirror;
    logic div_start;
    logic div_second;
    logic cap_qr;
    logic cap_bound;
    logic cap_tile;
    logic axis_row;
    logic load_result;
  } fmte_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_tile;
    logic err_tile;
    logic err_range;
    logic div_done;
  } fmte_sts_t;

endpackage

>>> src/fmte_div.sv
module fmte_div
  import fmte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dsr_q, dsr_d;
  logic [DIV_W-1:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= dsr_q) begin
        rem_d = trial - dsr_q;
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> src/fmte_datapath.sv
module fmte_datapath
  import fmte_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_write_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  fmte_in_t              in_data_i,
  output fmte_out_t             out_data_o,
  input  fmte_cmd_t             cmd_i,
  output fmte_sts_t             sts_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DIM_W-1:0] width_q, height_q, tile_q;
  mode_e            mode_q;

  fmte_in_t         item_q;
  logic [1:0]       status_q;
  logic [1:0]       status_d;
  logic [DIM_W-1:0] sc_q, sr_q;
  logic [DIV_W-1:0] q_q, r_q;
  logic [DIV_W-1:0] bound_q;
  logic [PIXEL_W-1:0] rdata_q;
  fmte_out_t        result_q;

  logic [PIXEL_W-1:0] mem [Depth];

  logic [DIM_W-1:0] w, h;
  logic [DIM_W-1:0] col_x, row_x;
  logic             err_range, err_tile, oob;
  logic [DIV_W-1:0] pos, size, big;
  logic             in_bound;
  logic [DIV_W-1:0] div_dividend, div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot, div_rem;
  logic [DIM_W-1:0] tile_src;
  logic [AW-1:0]    waddr, raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_FRAME_WIDTH;
      height_q <= RESET_FRAME_HEIGHT;
      mode_q   <= MODE_MIRROR_H;
      tile_q   <= RESET_TILE_FACTOR;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:    width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   height_q <= cfg_data_i[DIM_W-1:0];
        CFG_TRANSFORM_MODE: mode_q   <= mode_e'(cfg_data_i[1:0]);
        CFG_TILE_FACTOR:    tile_q   <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w = (32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
  assign h = (32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;

  assign col_x     = DIM_W'(item_q.col);
  assign row_x     = DIM_W'(item_q.row);
  assign err_range = (col_x >= w) || (row_x >= h);
  assign err_tile  = (mode_q == MODE_TILE) &&
                     ((tile_q == '0) || (tile_q > w) || (tile_q > h));

  always_comb begin
    if (item_q.opcode == OP_WRITE) begin
      status_d = err_range ? ST_RANGE : ST_OK;
    end else if (err_tile) begin
      status_d = ST_BAD_TILE;
    end else begin
      status_d = err_range ? ST_RANGE : ST_OK;
    end
  end

  // tile source along the current axis
  assign pos      = cmd_i.axis_row ? DIV_W'(row_x) : DIV_W'(col_x);
  assign size     = cmd_i.axis_row ? DIV_W'(h) : DIV_W'(w);
  assign big      = q_q + 1'b1;
  assign in_bound = pos < bound_q;

  always_comb begin
    if (cmd_i.div_second) begin
      div_dividend = in_bound ? pos : pos - bound_q;
      div_divisor  = in_bound ? big : q_q;
    end else begin
      div_dividend = size;
      div_divisor  = DIV_W'(tile_q);
    end
  end

  fmte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign tile_src = DIM_W'(div_rem * DIV_W'(tile_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_status) begin
      status_q <= status_d;
    end
    if (cmd_i.cap_mirror) begin
      sc_q <= (mode_q == MODE_MIRROR_H) ? w - 1'b1 - col_x : col_x;
      sr_q <= (mode_q == MODE_MIRROR_V) ? h - 1'b1 - row_x : row_x;
    end
    if (cmd_i.cap_qr) begin
      q_q <= div_quot;
      r_q <= div_rem;
    end
    if (cmd_i.cap_bound) begin
      bound_q <= DIV_W'(r_q * big);
    end
    if (cmd_i.cap_tile) begin
      if (cmd_i.axis_row) begin
        sr_q <= tile_src;
      end else begin
        sc_q <= tile_src;
      end
    end
  end

  assign waddr = AW'(32'(item_q.row) * MAX_WIDTH + 32'(item_q.col));
  assign raddr = AW'(32'(sr_q) * MAX_WIDTH + 32'(sc_q));
  assign oob   = (32'(sc_q) >= MAX_WIDTH) || (32'(sr_q) >= MAX_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      mem[waddr] <= item_q.pixel_in;
    end
    if (cmd_i.mem_read) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      result_q.status <= status_q;
      if ((item_q.opcode == OP_READ) && (status_q == ST_OK) && !oob) begin
        result_q.pixel_out <= rdata_q;
      end else begin
        result_q.pixel_out <= '0;
      end
    end
  end

  assign out_data_o = result_q;

  assign sts_o.is_write  = (item_q.opcode == OP_WRITE);
  assign sts_o.is_tile   = (mode_q == MODE_TILE);
  assign sts_o.err_tile  = err_tile;
  assign sts_o.err_range = err_range;
  assign sts_o.div_done  = div_done;

endmodule

>>> src/fmte_ctrl.sv
module fmte_ctrl
  import fmte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  fmte_sts_t sts_i,
  output fmte_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_START1 = 10'b0000000100,
    S_DIV1   = 10'b0000001000,
    S_BOUND  = 10'b0000010000,
    S_START2 = 10'b0000100000,
    S_DIV2   = 10'b0001000000,
    S_MUL    = 10'b0010000000,
    S_RDREQ  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.axis_row = axis_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.load_status = 1'b1;
        axis_d = 1'b0;
        if (sts_i.is_write) begin
          cmd_o.mem_write = !sts_i.err_range;
          state_d = S_DONE;
        end else if (sts_i.err_tile || sts_i.err_range) begin
          state_d = S_DONE;
        end else if (sts_i.is_tile) begin
          state_d = S_START1;
        end else begin
          cmd_o.cap_mirror = 1'b1;
          state_d = S_RDREQ;
        end
      end
      S_START1: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV1;
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.cap_qr = 1'b1;
          state_d = S_BOUND;
        end
      end
      S_BOUND: begin
        cmd_o.cap_bound = 1'b1;
        state_d = S_START2;
      end
      S_START2: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_second = 1'b1;
        state_d = S_DIV2;
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.cap_tile = 1'b1;
        if (axis_q) begin
          state_d = S_RDREQ;
        end else begin
          axis_d  = 1'b1;
          state_d = S_START1;
        end
      end
      S_RDREQ: begin
        cmd_o.mem_read = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/frame_mirror_tile_engine.sv
// Pixel frame store with mirror and tile readout. A write transaction stores one 32-bit pixel at
// (col,row); a read transaction returns the pixel at an output coordinate after a horizontal
// mirror, a vertical mirror, n-by-n tiled downsampling or no transform, per the configured mode. Every
// transaction gives one result with a status. One transaction is handled at a time. A tile-mode read
// makes four passes through the shared restoring divider (two per axis); other transactions do not
// use it. A finished result waits in the output register while the next transaction is taken.
// Pixels never written read back as undefined. The user must write configuration only while idle;
// the block itself does not enforce it.
module frame_mirror_tile_engine
  import fmte_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fmte_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fmte_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  fmte_cmd_t cmd;
  fmte_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fmte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmte_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> sim/fmte_result_checker.sv
module fmte_result_checker
  import fmte_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  fmte_in_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  fmte_out_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_MAX_W = 64;
  localparam int unsigned FRAME_MAX_H = 64;
  localparam int unsigned PRINT_CAP   = 100;

  logic [PIXEL_W-1:0] frame_copy [FRAME_MAX_W*FRAME_MAX_H];
  logic [DIM_W-1:0]   width_q  = RESET_FRAME_WIDTH;
  logic [DIM_W-1:0]   height_q = RESET_FRAME_HEIGHT;
  logic [DIM_W-1:0]   tiles_q  = RESET_TILE_FACTOR;
  mode_e              mode_q   = MODE_MIRROR_H;
  fmte_out_t          pending_pixels [$];
  int                 mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  initial begin
    foreach (frame_copy[i]) frame_copy[i] = '0;
  end

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // source position along one axis in tile mode, n in 1..size
  function automatic int unsigned tile_origin(int unsigned pos, int unsigned size,
                                              int unsigned n);
    int unsigned q;
    int unsigned rem;
    int unsigned bound;
    int unsigned off;
    q     = size / n;
    rem   = size % n;
    bound = rem * (q + 1);
    if (pos < bound) off = pos % (q + 1);
    else off = (pos - bound) % q;
    return off * n;
  endfunction

  function automatic fmte_out_t transform_pixel(fmte_in_t txn);
    fmte_out_t   res;
    int unsigned w;
    int unsigned h;
    int unsigned sc;
    int unsigned sr;
    res = '0;
    w   = (width_q > FRAME_MAX_W) ? FRAME_MAX_W : width_q;
    h   = (height_q > FRAME_MAX_H) ? FRAME_MAX_H : height_q;
    sc  = txn.col;
    sr  = txn.row;
    if (txn.opcode == OP_READ && mode_q == MODE_TILE &&
        (tiles_q < 1 || tiles_q > w || tiles_q > h)) begin
      res.status = ST_BAD_TILE;
    end else if (txn.col >= w || txn.row >= h) begin
      res.status = ST_RANGE;
    end else if (txn.opcode == OP_READ) begin
      case (mode_q)
        MODE_MIRROR_H: sc = w - 1 - txn.col;
        MODE_MIRROR_V: sr = h - 1 - txn.row;
        MODE_TILE: begin
          sc = tile_origin(txn.col, w, tiles_q);
          sr = tile_origin(txn.row, h, tiles_q);
        end
        default: ;
      endcase
      res.pixel_out = frame_copy[sr * FRAME_MAX_W + sc];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fmte_out_t want;
    if (!rst_ni) begin
      width_q  = RESET_FRAME_WIDTH;
      height_q = RESET_FRAME_HEIGHT;
      tiles_q  = RESET_TILE_FACTOR;
      mode_q   = MODE_MIRROR_H;
      pending_pixels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:    width_q  = cfg_data_i[DIM_W-1:0];
          CFG_FRAME_HEIGHT:   height_q = cfg_data_i[DIM_W-1:0];
          CFG_TRANSFORM_MODE: mode_q   = mode_e'(cfg_data_i[1:0]);
          CFG_TILE_FACTOR:    tiles_q  = cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("result with no transaction pending: pixel %h status %0d",
                                    out_data_i.pixel_out, out_data_i.status));
        end else begin
          want = pending_pixels.pop_front();
          if (out_data_i.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out %h, predicted %h",
                                      out_data_i.pixel_out, want.pixel_out));
          if (out_data_i.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_data_i.status, want.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = transform_pixel(in_data_i);
        pending_pixels.push_back(want);
        if (in_data_i.opcode == OP_WRITE && want.status == ST_OK)
          frame_copy[in_data_i.row * FRAME_MAX_W + in_data_i.col] = in_data_i.pixel_in;
      end
      pending_o <= pending_pixels.size();
    end
  end

endmodule

>>> sim/tb_frame_mirror_tile_engine.sv
module tb_frame_mirror_tile_engine;
  import fmte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 620;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned IDLE_PCT    = 17;
  localparam int unsigned SPAN_MAX    = 64;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  fmte_in_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  fmte_out_t             out_data;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int                    pending_cnt;
  int                    fail_cnt;
  int unsigned           cycle_cnt   = 0;
  int unsigned           items_sent  = 0;
  logic                  calm        = 1'b0;
  int unsigned           span_w      = 64;
  int unsigned           span_h      = 64;
  bit                    frame_loaded [SPAN_MAX][SPAN_MAX];

  frame_mirror_tile_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fmte_result_checker result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending_cnt),
    .mismatches_o (fail_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic fmte_in_t pixel_txn(logic op, int unsigned c, int unsigned r,
                                         logic [PIXEL_W-1:0] p);
    fmte_in_t t;
    t.opcode   = op;
    t.col      = COORD_W'(c);
    t.row      = COORD_W'(r);
    t.pixel_in = p;
    return t;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned v, int unsigned bits);
    logic [CFG_DATA_W-1:0] mask;
    mask = {CFG_DATA_W{1'b1}} << bits;
    if ($urandom_range(3) == 0) return CFG_DATA_W'(v) | ($urandom() & mask);
    return CFG_DATA_W'(v);
  endfunction

  task automatic send_item(input fmte_in_t txn);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= txn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (txn.opcode == OP_WRITE && txn.col < span_w && txn.row < span_h)
      frame_loaded[txn.row][txn.col] = 1'b1;
    items_sent++;
    calm = (items_sent >= 300 && items_sent < 420);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input mode_e mode,
                            input int unsigned tf);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, with_noise(w & 32'h7F, DIM_W));
    write_reg(CFG_FRAME_HEIGHT, with_noise(h & 32'h7F, DIM_W));
    write_reg(CFG_TRANSFORM_MODE, with_noise(int'(mode), 2));
    write_reg(CFG_TILE_FACTOR, with_noise(tf & 32'h7F, DIM_W));
    cfg_valid <= 1'b0;
    span_w = ((w & 32'h7F) > SPAN_MAX) ? SPAN_MAX : (w & 32'h7F);
    span_h = ((h & 32'h7F) > SPAN_MAX) ? SPAN_MAX : (h & 32'h7F);
  endtask

  // every pixel of the visible frame is written before any read can land on it
  task automatic fill_frame();
    for (int r = 0; r < span_h; r++)
      for (int c = 0; c < span_w; c++)
        if (!frame_loaded[r][c]) send_item(pixel_txn(OP_WRITE, c, r, $urandom()));
  endtask

  task automatic run_directed();
    send_item(pixel_txn(OP_WRITE, 0, 0, 32'hFFFF_FFFF));
    send_item(pixel_txn(OP_WRITE, 63, 63, 32'h0000_0000));
    send_item(pixel_txn(OP_WRITE, 63, 0, 32'h8000_0001));
    send_item(pixel_txn(OP_WRITE, 0, 63, 32'h7FFF_FFFE));
    send_item(pixel_txn(OP_READ, 0, 0, 32'h0000_0000));
    send_item(pixel_txn(OP_READ, 63, 63, 32'hFFFF_FFFF));
    // zero width
    set_config(0, 64, MODE_MIRROR_H, 1);
    send_item(pixel_txn(OP_WRITE, 0, 0, 32'h1234_5678));
    send_item(pixel_txn(OP_READ, 0, 0, 32'h0000_0000));
    // tile factor zero, then above the width
    set_config(2, 2, MODE_TILE, 0);
    send_item(pixel_txn(OP_READ, 0, 0, 32'h0000_0000));
    set_config(2, 2, MODE_TILE, 3);
    send_item(pixel_txn(OP_READ, 1, 1, 32'h0000_0000));
    set_config(2, 2, MODE_TILE, 2);
    fill_frame();
    send_item(pixel_txn(OP_READ, 1, 1, 32'h0000_0000));
    send_item(pixel_txn(OP_READ, 5, 0, 32'h0000_0000));
    send_item(pixel_txn(OP_WRITE, 2, 1, 32'hDEAD_BEEF));
    set_config(2, 2, MODE_MIRROR_V, 1);
    send_item(pixel_txn(OP_READ, 0, 1, 32'h0000_0000));
    set_config(2, 2, MODE_DIRECT, 1);
    send_item(pixel_txn(OP_READ, 1, 0, 32'h0000_0000));
    // width above maximum, tile factor above the height
    set_config(127, 1, MODE_TILE, 64);
    send_item(pixel_txn(OP_READ, 0, 0, 32'h0000_0000));
  endtask

  task automatic run_random_phase();
    int unsigned        pick;
    int unsigned        w;
    int unsigned        h;
    int unsigned        tf;
    int unsigned        narrow;
    int unsigned        n_items;
    int unsigned        c;
    int unsigned        r;
    logic               op;
    logic [PIXEL_W-1:0] p;
    mode_e              mode;
    pick = $urandom_range(99);
    if (pick < 55) begin
      w = $urandom_range(8, 1);
      h = $urandom_range(8, 1);
    end else if (pick < 70) begin
      w = $urandom_range(127, 1);
      h = $urandom_range(3, 1);
    end else if (pick < 85) begin
      w = $urandom_range(3, 1);
      h = $urandom_range(127, 1);
    end else if (pick < 92) begin
      w = $urandom_range(16, 9);
      h = $urandom_range(16, 9);
    end else if ($urandom_range(1) == 0) begin
      w = 0;
      h = $urandom_range(127, 0);
    end else begin
      w = $urandom_range(127, 0);
      h = 0;
    end
    pick = $urandom_range(99);
    if (pick < 40) mode = MODE_TILE;
    else if (pick < 60) mode = MODE_MIRROR_H;
    else if (pick < 80) mode = MODE_MIRROR_V;
    else mode = MODE_DIRECT;
    narrow = ((w > SPAN_MAX) ? SPAN_MAX : w) < ((h > SPAN_MAX) ? SPAN_MAX : h) ?
             ((w > SPAN_MAX) ? SPAN_MAX : w) : ((h > SPAN_MAX) ? SPAN_MAX : h);
    pick = $urandom_range(99);
    if (pick < 75 && narrow > 0) tf = $urandom_range(narrow, 1);
    else if (pick < 85) tf = 0;
    else if (pick < 95) tf = $urandom_range(127, narrow + 1);
    else tf = $urandom_range(127, 0);
    set_config(w, h, mode, tf);
    fill_frame();
    n_items = $urandom_range(45, 15);
    for (int i = 0; i < n_items; i++) begin
      op = ($urandom_range(99) < 55) ? OP_READ : OP_WRITE;
      if (span_w > 0 && span_h > 0 && $urandom_range(99) < 80) begin
        c = $urandom_range(span_w - 1, 0);
        r = $urandom_range(span_h - 1, 0);
      end else begin
        c = $urandom_range(63, 0);
        r = $urandom_range(63, 0);
      end
      pick = $urandom_range(99);
      if (pick < 10) p = 32'h0000_0000;
      else if (pick < 20) p = 32'hFFFF_FFFF;
      else p = $urandom();
      send_item(pixel_txn(op, c, r, p));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (items_sent < ITEM_TARGET) run_random_phase();
    wait_idle();
    repeat (60) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> frame_mirror_tile_engine.f
src/fmte_pkg.sv
src/fmte_div.sv
src/fmte_datapath.sv
src/fmte_ctrl.sv
src/frame_mirror_tile_engine.sv
sim/fmte_result_checker.sv
sim/tb_frame_mirror_tile_engine.sv
